// File: hw/rtl/nrsh_pkg.sv
package nrsh_pkg;

    localparam int COORD_W  = 32;
    localparam int DIR_W    = 18;
    localparam int RAD_W    = 31;
    localparam int IDX_W    = 3;
    localparam int SQ_W     = 66;

    localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd6;

    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

    // Saturate a 34 bit signed value to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sd2147483647)
                r = I32_MAX;
            else if (v < -34'sd2147483648)
                r = I32_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // Square root request and response between the sequencer and the root unit.
    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

endpackage

// File: hw/rtl/nrsh_if.sv
interface nrsh_particle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] particle_z;
    logic               final_particle;
    modport source (output valid, particle_x, particle_y, particle_z, final_particle,
                    input ready);
    modport sink (input valid, particle_x, particle_y, particle_z, final_particle,
                  output ready);
endinterface

interface nrsh_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] hit_distance;
    logic               any_hit;
    modport source (output valid, hit_distance, any_hit, input ready);
    modport sink (input valid, hit_distance, any_hit, output ready);
endinterface

interface nrsh_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/nrsh_sqrt.sv
module nrsh_sqrt
    import nrsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    // Restoring square root, one result bit per cycle.
    logic [63:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] src_reg, src_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;
    logic [63:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[61:0], src_reg[63:62]};
        trial     = {root_reg[29:0], 2'b01} | 64'd0;
        trial     = {30'd0, root_reg, 2'b01};
        if (req.start)
        begin
            rem_next  = '0;
            root_next = '0;
            src_next  = req.radicand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            src_next = {src_reg[61:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        src_reg  <= src_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done) else $error("sqrt done held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg) else $error("sqrt done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("sqrt did not start");
`endif

endmodule

// File: hw/rtl/nearest_ray_sphere_hit.sv
// Every particle passes eight times through the shared multiplier; one whose sphere is hit
// then also waits for the bit-serial square root, while a miss goes on without it.
// A final particle adds an output state, and a fallback root when nothing hit.
// The block is not ready for a new particle while busy.
// Reset (rst_n, asynchronous, active low) restores register defaults and the scan state.
module nearest_ray_sphere_hit
    import nrsh_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    nrsh_cfg_if.sink     cfg,
    nrsh_particle_if.sink particle,
    nrsh_result_if.source result
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUB  = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_B    = 4'd3;
    localparam logic [3:0] ST_BB   = 4'd4;
    localparam logic [3:0] ST_CMP  = 4'd5;
    localparam logic [3:0] ST_ROOT = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_FB   = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // Configuration registers.
    logic signed [31:0] org_reg [3];
    logic signed [17:0] dir_reg [3];
    logic [30:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= 18'sd65536;
            rad_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ORIGIN_X: org_reg[0] <= cfg.data;
                REG_ORIGIN_Y: org_reg[1] <= cfg.data;
                REG_ORIGIN_Z: org_reg[2] <= cfg.data;
                REG_DIR_X:    dir_reg[0] <= cfg.data[17:0];
                REG_DIR_Y:    dir_reg[1] <= cfg.data[17:0];
                REG_DIR_Z:    dir_reg[2] <= cfg.data[17:0];
                REG_RADIUS:   rad_reg    <= cfg.data[30:0];
                default: ;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    // Sequencer state and datapath registers.
    logic [3:0]         st_reg, st_next;
    logic [3:0]         step_reg, step_next;
    logic signed [31:0] p_reg [3];
    logic               fin_reg;
    logic signed [31:0] op_reg [3];
    logic signed [51:0] dot_reg, dot_next;
    logic [65:0]        d2_reg, d2_next;
    logic [65:0]        sum_reg, sum_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [31:0] near_reg, near_next;
    logic               seen_reg, seen_next;
    logic [63:0]        far_reg, far_next;
    logic signed [31:0] res_d_reg, res_d_next;
    logic               res_h_reg, res_h_next;
    sqrt_req_t          sq_req;
    sqrt_rsp_t          sq_rsp;

    // Shared 33 by 33 signed multiplier, operands chosen by the step.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [1:0]         lane;
    logic signed [51:0] dot_sh;
    logic signed [31:0] bsat;
    logic signed [33:0] entry_dist;
    assign lane = step_reg[1:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (st_reg == ST_MUL)
        begin
            if (step_reg[2])
            begin
                mul_a = {op_reg[lane][31], op_reg[lane]};
                mul_b = {op_reg[lane][31], op_reg[lane]};
            end
            else
            begin
                mul_a = {op_reg[lane][31], op_reg[lane]};
                mul_b = 33'(dir_reg[lane]);
            end
        end
        else if (st_reg == ST_BB)
        begin
            if (step_reg[0])
            begin
                mul_a = {2'b00, rad_reg};
                mul_b = {2'b00, rad_reg};
            end
            else
            begin
                mul_a = {b_reg[31], b_reg};
                mul_b = {b_reg[31], b_reg};
            end
        end
    end
    assign mul_p = mul_a * mul_b;

    // The shifted dot product can exceed 34 bits, so saturate at full width.
    assign dot_sh = dot_reg >>> 16;
    assign bsat   = (dot_sh > 52'sd2147483647) ? I32_MAX :
                    (dot_sh < -52'sd2147483648) ? I32_MIN : dot_sh[31:0];
    assign entry_dist = 34'(b_reg) - 34'($signed({1'b0, sq_rsp.root}));

    always_comb
    begin
        st_next    = st_reg;
        step_next  = step_reg;
        dot_next   = dot_reg;
        d2_next    = d2_reg;
        sum_next   = sum_reg;
        b_next     = b_reg;
        near_next  = near_reg;
        seen_next  = seen_reg;
        far_next   = far_reg;
        res_d_next = res_d_reg;
        res_h_next = res_h_reg;
        sq_req.start    = 1'b0;
        sq_req.radicand = far_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (particle.valid)
                    st_next = ST_SUB;
            end
            ST_SUB:
            begin
                dot_next  = '0;
                d2_next   = '0;
                step_next = '0;
                st_next   = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg[2])
                    d2_next = d2_reg + 66'(mul_p);
                else
                    dot_next = dot_reg + 52'(mul_p);
                if (step_reg[1:0] == 2'd2)
                    step_next = step_reg[2] ? 4'd0 : 4'd4;
                else
                    step_next = step_reg + 4'd1;
                if (step_reg == 4'd6)
                    st_next = ST_B;
            end
            ST_B:
            begin
                b_next = bsat;
                if (d2_reg[63:0] > far_reg)
                    far_next = d2_reg[63:0];
                step_next = '0;
                st_next   = ST_BB;
            end
            ST_BB:
            begin
                if (step_reg[0])
                begin
                    sum_next = sum_reg + 66'(mul_p);
                    st_next  = ST_CMP;
                end
                else
                    sum_next = 66'(mul_p);
                step_next = step_reg + 4'd1;
            end
            ST_CMP:
            begin
                if (sum_reg >= d2_reg)
                begin
                    sq_req.start    = 1'b1;
                    sq_req.radicand = 64'(sum_reg - d2_reg);
                    st_next         = ST_ROOT;
                end
                else
                    st_next = ST_FIN;
            end
            ST_ROOT:
            begin
                if (sq_rsp.done)
                begin
                    if (sat34(entry_dist) < near_reg)
                        near_next = sat34(entry_dist);
                    seen_next = 1'b1;
                    st_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!fin_reg)
                    st_next = ST_IDLE;
                else if (seen_reg)
                begin
                    res_d_next = near_reg;
                    res_h_next = 1'b1;
                    st_next    = ST_OUT;
                end
                else
                begin
                    sq_req.start = 1'b1;
                    st_next      = ST_FB;
                end
            end
            ST_FB:
            begin
                if (sq_rsp.done)
                begin
                    res_d_next = sq_rsp.root[31] ? I32_MAX : sq_rsp.root;
                    res_h_next = 1'b0;
                    st_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                near_next = I32_MAX;
                seen_next = 1'b0;
                far_next  = '0;
                if (result.ready)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            step_reg <= '0;
            near_reg <= I32_MAX;
            seen_reg <= 1'b0;
            far_reg  <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            near_reg <= near_next;
            seen_reg <= seen_next;
            far_reg  <= far_next;
        end
    end

    // Payload registers; the particle word is captured on acceptance.
    always_ff @(posedge clk)
    begin
        dot_reg   <= dot_next;
        d2_reg    <= d2_next;
        sum_reg   <= sum_next;
        b_reg     <= b_next;
        res_d_reg <= res_d_next;
        res_h_reg <= res_h_next;
        if (st_reg == ST_IDLE && particle.valid)
        begin
            p_reg[0] <= particle.particle_x;
            p_reg[1] <= particle.particle_y;
            p_reg[2] <= particle.particle_z;
            fin_reg  <= particle.final_particle;
        end
        if (st_reg == ST_SUB)
        begin
            op_reg[0] <= sat34(34'(p_reg[0]) - 34'(org_reg[0]));
            op_reg[1] <= sat34(34'(p_reg[1]) - 34'(org_reg[1]));
            op_reg[2] <= sat34(34'(p_reg[2]) - 34'(org_reg[2]));
        end
    end

    nrsh_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    assign particle.ready      = (st_reg == ST_IDLE);
    assign result.valid        = (st_reg == ST_OUT);
    assign result.hit_distance = res_d_reg;
    assign result.any_hit      = res_h_reg;

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.hit_distance))
        else $error("result word dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_IDLE |-> !particle.ready) else $error("ready while busy");
    a_seen_near: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> near_reg == I32_MAX) else $error("nearest set without hit");
`endif

endmodule
